// ===== rtl/isr64_pkg.sv =====
package isr64_pkg;

    localparam int unsigned RAD_W  = 64;
    localparam int unsigned ROOT_W = 32;

    typedef logic [RAD_W-1:0]  t_radicand;
    typedef logic [ROOT_W-1:0] t_root;

endpackage

// ===== rtl/isr64_cell.sv =====
module isr64_cell #(
    parameter int unsigned STEPS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [2*STEPS-1:0]   i_rad,
    input  logic [STEPS:0]       i_rem,
    input  logic [STEPS-1:0]     i_root,
    output logic                 o_valid,
    output logic [2*STEPS-1:0]   o_rad,
    output logic [STEPS:0]       o_rem,
    output logic [STEPS-1:0]     o_root
);

    localparam int unsigned PW = 2 * STEPS;
    localparam int unsigned RW = STEPS + 1;
    localparam int unsigned CW = RW + 2;

    logic          r_valid;
    logic [PW-1:0] r_rad;
    logic [RW-1:0] r_rem;
    logic [STEPS-1:0] r_root;

    logic [PW-1:0]    n_rad;
    logic [RW-1:0]    n_rem;
    logic [STEPS-1:0] n_root;

    logic [CW-1:0] w_cur;
    logic [CW-1:0] w_trial;
    logic [CW-1:0] w_diff;
    logic          w_fits;

    // Bring down the next two radicand bits and try the partial root with a one appended.
    always_comb begin
        w_cur   = {i_rem, i_rad[PW-1 -: 2]};
        w_trial = CW'({i_root, 2'b01});
        w_fits  = (w_cur >= w_trial);
        w_diff  = w_cur - w_trial;
        n_rem   = w_fits ? w_diff[RW-1:0] : w_cur[RW-1:0];
        n_root  = STEPS'({i_root, w_fits});
        n_rad   = i_rad << 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;

endmodule

// ===== rtl/integer_square_root_64_core.sv =====
// Floor square root of an unsigned radicand, one root bit per cell in a chain of
// (RADICAND_WIDTH + 1) / 2 cells, 32 at the default width. A beat is accepted in every
// cycle, so busy stays low, and each result appears with o_strobe once it has passed
// the register in every cell of the chain. The strobe lasts one cycle and cannot be
// held off. Widths below 64 use only the low radicand bits; widths above 64 act as 64.
module integer_square_root_64_core #(
    parameter int unsigned RADICAND_WIDTH = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  isr64_pkg::t_radicand    i_radicand,
    output logic                    o_strobe,
    output isr64_pkg::t_root        o_root
);

    import isr64_pkg::*;

    localparam int unsigned W_CLAMP = (RADICAND_WIDTH > RAD_W) ? RAD_W : RADICAND_WIDTH;
    localparam int unsigned W_USED  = (W_CLAMP < 2) ? 2 : W_CLAMP;
    localparam int unsigned STEPS   = (W_USED + 1) / 2;
    localparam int unsigned PW      = 2 * STEPS;

    logic              w_valid [STEPS+1];
    logic [PW-1:0]     w_rad   [STEPS+1];
    logic [STEPS:0]    w_rem   [STEPS+1];
    logic [STEPS-1:0]  w_root  [STEPS+1];
    logic [PW-1:0]     w_rad_used;

    assign w_rad_used = PW'(i_radicand[W_USED-1:0]);

    assign w_valid[0] = start && !busy;
    assign w_rad[0]   = w_rad_used;
    assign w_rem[0]   = '0;
    assign w_root[0]  = '0;

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        isr64_cell #(
            .STEPS(STEPS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_rad   (w_rad[g]),
            .i_rem   (w_rem[g]),
            .i_root  (w_root[g]),
            .o_valid (w_valid[g+1]),
            .o_rad   (w_rad[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_root  (w_root[g+1])
        );
    end

    assign busy     = 1'b0;
    assign o_strobe = w_valid[STEPS];
    assign o_root   = ROOT_W'(w_root[STEPS]);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##STEPS o_strobe)
        else $error("Accepted beat did not produce a result after the cell chain.");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, STEPS))
        else $error("Result strobe without a matching accepted beat.");

    a_root_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((PW+1)'(w_root[STEPS]) * (PW+1)'(w_root[STEPS])
                      <= (PW+1)'($past(w_rad_used, STEPS))))
        else $error("Root squared exceeds the radicand.");

    a_root_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (((PW+1)'(w_root[STEPS]) + 1'b1) * ((PW+1)'(w_root[STEPS]) + 1'b1)
                      > (PW+1)'($past(w_rad_used, STEPS))))
        else $error("Root is smaller than the floor square root.");

endmodule

// ===== test/tb_top.sv =====
class root_scoreboard;
    isr64_pkg::t_root expected_roots[$];
    int unsigned      n_errors;
    int unsigned      n_checked;

    function new();
        n_errors  = 0;
        n_checked = 0;
    endfunction

    static function isr64_pkg::t_root floor_root(isr64_pkg::t_radicand value);
        logic [63:0] remainder;
        logic [63:0] partial;
        logic [63:0] weight;
        remainder = value;
        partial   = '0;
        weight    = 64'h1 << 62;
        for (int step = 0; step < 32; step++) begin
            if (remainder >= partial + weight) begin
                remainder = remainder - (partial + weight);
                partial   = (partial >> 1) + weight;
            end else begin
                partial = partial >> 1;
            end
            weight = weight >> 2;
        end
        return partial[31:0];
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        n_errors++;
    endtask

    function void note_radicand(isr64_pkg::t_radicand value);
        expected_roots.push_back(floor_root(value));
    endfunction

    task check_root(isr64_pkg::t_root got);
        isr64_pkg::t_root want;
        n_checked++;
        if (expected_roots.size() == 0) begin
            report($sformatf("root %h arrived with nothing outstanding", got));
        end else begin
            want = expected_roots.pop_front();
            if (got !== want) begin
                report($sformatf("root %h, wanted %h", got, want));
            end
        end
    endtask

    function int unsigned pending();
        return expected_roots.size();
    endfunction
endclass

module tb_top;
    import isr64_pkg::*;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_radicand i_radicand;
    logic      o_strobe;
    t_root     o_root;

    root_scoreboard sb;
    int unsigned    n_narrow;
    int unsigned    n_near_square;
    int unsigned    n_wide;
    int unsigned    burst_left;

    integer_square_root_64_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_radicand (i_radicand),
        .o_strobe   (o_strobe),
        .o_root     (o_root)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            sb.check_root(o_root);
        end
    end

    function automatic t_radicand rand64();
        return {$urandom, $urandom};
    endfunction

    // One beat: hold start until the block takes the radicand.
    task automatic send_radicand(t_radicand value);
        start      <= 1'b1;
        i_radicand <= value;
        do @(posedge i_clk); while (busy);
        sb.note_radicand(value);
        if (value[63:32] == '0) n_narrow++;
        else n_wide++;
    endtask

    task automatic idle_for(int unsigned cycles);
        if (cycles != 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic random_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (burst_left != 0) begin
            burst_left--;
        end else if (pick < 3) begin
            burst_left = $urandom_range(20, 60);
        end else if (pick < 60) begin
            idle_for(0);
        end else if (pick < 88) begin
            idle_for($urandom_range(1, 3));
        end else if (pick < 97) begin
            idle_for($urandom_range(4, 12));
        end else begin
            idle_for($urandom_range(20, 60));
        end
    endtask

    task automatic wait_for_drain(int unsigned limit);
        int unsigned waited;
        waited = 0;
        start <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (sb.pending() != 0 && waited < limit);
    endtask

    function automatic t_radicand random_radicand();
        t_radicand   value;
        logic [31:0] base;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: begin
                value = rand64();
            end
            4: begin
                value = {32'h0, $urandom};
            end
            5: begin
                base  = $urandom;
                value = 64'(base) * 64'(base) + 64'($signed($urandom_range(0, 2)) - 1);
            end
            6: begin
                value = rand64() >> $urandom_range(0, 63);
            end
            7: begin
                value = 64'($urandom_range(0, 1023));
            end
            8: begin
                value = 64'h1 << $urandom_range(0, 63);
                if ($urandom_range(0, 1) == 1) value = ~value;
            end
            default: begin
                value = 64'h1_0000_0000 + 64'($signed($urandom_range(0, 64)) - 32);
            end
        endcase
        return value;
    endfunction

    t_radicand directed_values[$] = '{
        64'h0, 64'h1, 64'h2, 64'h3, 64'h4, 64'h8, 64'h9, 64'hF, 64'h10, 64'h18, 64'h19,
        64'hFFFE_0001, 64'hFFFF_FFFF, 64'h1_0000_0000, 64'h1_0000_0001,
        64'hFFFF_FFFE_0000_0000, 64'hFFFF_FFFE_0000_0001, 64'hFFFF_FFFE_0000_0002,
        64'h3FFF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF
    };

    initial begin
        t_radicand value;
        sb            = new();
        n_narrow      = 0;
        n_wide        = 0;
        n_near_square = 0;
        burst_left    = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_radicand    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_values[k]) begin
            send_radicand(directed_values[k]);
        end
        wait_for_drain(5000);

        for (int n = 0; n < 1350; n++) begin
            value = random_radicand();
            if (sb.floor_root(value) == sb.floor_root(value + 64'h1) - 32'h1
                    || sb.floor_root(value) == sb.floor_root(value - 64'h1) + 32'h1) begin
                n_near_square++;
            end
            send_radicand(value);
            if ($urandom_range(0, 299) == 0) begin
                wait_for_drain(5000);
            end else begin
                random_gap();
            end
        end

        wait_for_drain(5000);
        repeat (40) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d roots never arrived", sb.pending()));
        end

        $display("Checked %0d roots: %0d radicands below 2^32, %0d at or above it,",
                 sb.n_checked, n_narrow, n_wide);
        $display("%0d random radicands next to a perfect square; %0d mismatches.",
                 n_near_square, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("PASS integer_square_root_64_core");
        end else begin
            $display("FAIL integer_square_root_64_core");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL integer_square_root_64_core");
        $finish;
    end
endmodule

// ===== integer_square_root_64_core.f =====
rtl/isr64_pkg.sv
rtl/isr64_cell.sv
rtl/integer_square_root_64_core.sv
test/tb_top.sv
